/* design/nsc_pkg.sv */
// ----------------------------------------------------------------------------
// nsc_pkg
// Types and constants shared by the nearest shape lookup core: request and
// response payloads, table row layout, state encoding and divider sizing.
// ----------------------------------------------------------------------------
package nsc_pkg;

   localparam int DIM_W      = 16;
   localparam int TILE_W     = 5;
   localparam int BLK_W      = 7;
   localparam int FLAG_W     = 5;
   localparam int ROW_IDX_W  = 6;
   localparam int CNT_W      = 7;
   localparam int DIST_W     = 2 * DIM_W + 2;
   localparam int DIV_BITS   = 4;
   localparam int DIV_CYCLES = DIM_W / DIV_BITS;
   localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic [DIM_W-1:0] dim_m;
      logic [DIM_W-1:0] dim_n;
      logic [DIM_W-1:0] dim_k;
      logic [DIM_W-1:0] dim_b;
   } shape_key_type;

   typedef struct packed {
      logic [TILE_W-1:0] tile_m;
      logic [TILE_W-1:0] tile_n;
      logic [TILE_W-1:0] tile_k;
      logic [BLK_W-1:0]  lhs_blocks;
      logic [BLK_W-1:0]  rhs_blocks;
      logic [FLAG_W-1:0] layout_flags;
   } tile_set_type;

   typedef struct packed {
      shape_key_type key;
      tile_set_type  tile;
   } row_type;

   typedef struct packed {
      logic              mode;
      logic [ROW_IDX_W-1:0] row_index;
      logic [DIM_W-1:0]  dim_m;
      logic [DIM_W-1:0]  dim_n;
      logic [DIM_W-1:0]  dim_k;
      logic [DIM_W-1:0]  dim_b;
      logic [TILE_W-1:0] tile_m;
      logic [TILE_W-1:0] tile_n;
      logic [TILE_W-1:0] tile_k;
      logic [BLK_W-1:0]  lhs_blocks;
      logic [BLK_W-1:0]  rhs_blocks;
      logic [FLAG_W-1:0] layout_flags;
   } req_type;

   typedef struct packed {
      logic [ROW_IDX_W-1:0] best_row;
      logic [TILE_W-1:0] out_tile_m;
      logic [TILE_W-1:0] out_tile_n;
      logic [TILE_W-1:0] out_tile_k;
      logic [BLK_W-1:0]  out_lhs_blocks;
      logic [DIM_W-1:0]  out_rhs_blocks;
      logic [FLAG_W-1:0] out_layout_flags;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV
   } state_type;

endpackage

/* design/nsc_cell.sv */
// ----------------------------------------------------------------------------
// nsc_cell
// One table row of the ring. Loads its row when addressed, and during a
// query takes the row of its neighbor every cycle.
// ----------------------------------------------------------------------------
module nsc_cell import nsc_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int INDEX = 0
) (
   input  logic                 clock,
   input  logic                 load_en,
   input  logic [ROW_IDX_W-1:0] load_idx,
   input  row_type              load_row,
   input  logic                 shift_en,
   input  row_type              next_row,
   output row_type              row
);

   localparam int SEL_W = (($clog2(DEPTH) > ROW_IDX_W) ? $clog2(DEPTH) : ROW_IDX_W) + 1;

   row_type row_ff;
   row_type row_in;
   logic    hit;

   assign hit = load_en && (SEL_W'(load_idx) == SEL_W'(INDEX));

   always_comb begin
      row_in = row_ff;
      if (shift_en) begin
         row_in = next_row;
      end else if (hit) begin
         row_in = load_row;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   assign row = row_ff;

endmodule

/* design/nsc_scan.sv */
// ----------------------------------------------------------------------------
// nsc_scan
// Distance pipeline at the head of the ring: absolute differences, squares,
// sum, then a running minimum that keeps the first row on ties.
// ----------------------------------------------------------------------------
module nsc_scan import nsc_pkg::*; #(
   parameter int IDX_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             feed,
   input  logic [IDX_W-1:0] feed_idx,
   input  row_type          feed_row,
   input  shape_key_type    query,
   input  logic [CNT_W-1:0] rows_in_use,
   output logic             busy,
   output logic [IDX_W-1:0] best_idx,
   output tile_set_type     best_tile
);

   localparam int SEL_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

   function automatic logic [DIM_W-1:0] abs_diff(input logic [DIM_W-1:0] a,
                                                 input logic [DIM_W-1:0] b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

   logic                 v1_ff, v2_ff, v3_ff;
   logic [IDX_W-1:0]     idx1_ff, idx2_ff, idx3_ff;
   tile_set_type         tile1_ff, tile2_ff, tile3_ff;
   logic [DIM_W-1:0]     d1_ff [4];
   logic [2*DIM_W-1:0]   sq2_ff [4];
   logic [DIST_W-1:0]    sum3_ff;
   logic [DIST_W-1:0]    best_dist_ff;
   logic [IDX_W-1:0]     best_idx_ff;
   tile_set_type         best_tile_ff;
   logic                 used;
   logic                 take;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= feed;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff  <= feed_idx;
      tile1_ff <= feed_row.tile;
      d1_ff[0] <= abs_diff(query.dim_m, feed_row.key.dim_m);
      d1_ff[1] <= abs_diff(query.dim_n, feed_row.key.dim_n);
      d1_ff[2] <= abs_diff(query.dim_k, feed_row.key.dim_k);
      d1_ff[3] <= abs_diff(query.dim_b, feed_row.key.dim_b);
      idx2_ff  <= idx1_ff;
      tile2_ff <= tile1_ff;
      sq2_ff[0] <= d1_ff[0] * d1_ff[0];
      sq2_ff[1] <= d1_ff[1] * d1_ff[1];
      sq2_ff[2] <= d1_ff[2] * d1_ff[2];
      sq2_ff[3] <= d1_ff[3] * d1_ff[3];
      idx3_ff  <= idx2_ff;
      tile3_ff <= tile2_ff;
      sum3_ff  <= DIST_W'(sq2_ff[0]) + DIST_W'(sq2_ff[1])
                + DIST_W'(sq2_ff[2]) + DIST_W'(sq2_ff[3]);
   end

   assign used = SEL_W'(idx3_ff) < SEL_W'(rows_in_use);
   assign take = v3_ff && ((idx3_ff == '0) || (used && (sum3_ff < best_dist_ff)));

   always_ff @(posedge clock) begin
      if (take) begin
         best_dist_ff <= sum3_ff;
         best_idx_ff  <= idx3_ff;
         best_tile_ff <= tile3_ff;
      end
   end

   assign busy      = v1_ff | v2_ff | v3_ff;
   assign best_idx  = best_idx_ff;
   assign best_tile = best_tile_ff;

endmodule

/* design/nsc_div.sv */
// ----------------------------------------------------------------------------
// nsc_div
// Restoring divider of a dimension by a tile size, several quotient bits
// per cycle.
// ----------------------------------------------------------------------------
module nsc_div import nsc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIM_W-1:0]  dividend,
   input  logic [TILE_W-1:0] divisor,
   output logic              busy,
   output logic [DIM_W-1:0]  quotient
);

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIM_W-1:0]     num_ff, num_in;
   logic [TILE_W-1:0]    rem_ff, rem_in;
   logic [TILE_W-1:0]    div_ff;
   logic [TILE_W:0]      trial;
   logic                 ge;

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      trial  = '0;
      ge     = 1'b0;
      for (int j = 0; j < DIV_BITS; j++) begin
         trial  = {rem_in, num_in[DIM_W-1]};
         ge     = trial >= {1'b0, div_ff};
         num_in = {num_in[DIM_W-2:0], ge};
         rem_in = ge ? TILE_W'(trial - {1'b0, div_ff}) : trial[TILE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = num_ff;

endmodule

/* design/nearest_shape_config_lookup_core.sv */
// ----------------------------------------------------------------------------
// nearest_shape_config_lookup_core
// Nearest shape table lookup returning tile settings for a matrix shape.
// ----------------------------------------------------------------------------
// A load request writes one table row and returns nothing.
// A query request rotates the ring of TABLE_DEPTH row cells once past a single
// squared distance pipeline, one row per cycle, then divides m and n by the
// chosen tile sizes; the block accepts no new request until the response is
// loaded. A waiting response does not block the next request. Rows that were
// never loaded must not fall inside rows_in_use.
// ----------------------------------------------------------------------------
module nearest_shape_config_lookup_core import nsc_pkg::*; #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CNT_W-1:0] csr_wdata
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] shift_cnt_ff, shift_cnt_in;
   logic [CNT_W-1:0] rows_in_use_ff;
   shape_key_type    query_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             req_fire;
   logic             load_en;
   logic             shift_en;
   logic             feed;
   logic             div_start;
   logic             rsp_load;
   row_type          load_row;
   row_type          ring [TABLE_DEPTH];

   logic             scan_busy;
   logic [IDX_W-1:0] best_idx;
   tile_set_type     best_tile;

   logic             busy_m, busy_n;
   logic [DIM_W-1:0] quot_m, quot_n;
   logic [TILE_W-1:0] div_m, div_n;
   logic [DIM_W-1:0] lhs_min;
   logic [DIM_W-1:0] rhs_min;

   assign req_fire  = req_valid && req_ready;
   assign load_en   = req_fire && (req_data.mode == MODE_LOAD);
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   assign load_row.key.dim_m         = req_data.dim_m;
   assign load_row.key.dim_n         = req_data.dim_n;
   assign load_row.key.dim_k         = req_data.dim_k;
   assign load_row.key.dim_b         = req_data.dim_b;
   assign load_row.tile.tile_m       = req_data.tile_m;
   assign load_row.tile.tile_n       = req_data.tile_n;
   assign load_row.tile.tile_k       = req_data.tile_k;
   assign load_row.tile.lhs_blocks   = req_data.lhs_blocks;
   assign load_row.tile.rhs_blocks   = req_data.rhs_blocks;
   assign load_row.tile.layout_flags = req_data.layout_flags;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      nsc_cell #(
         .DEPTH (TABLE_DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .load_en  (load_en),
         .load_idx (req_data.row_index),
         .load_row (load_row),
         .shift_en (shift_en),
         .next_row (ring[(i + 1) % TABLE_DEPTH]),
         .row      (ring[i])
      );
   end

   nsc_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .feed        (feed),
      .feed_idx    (shift_cnt_ff),
      .feed_row    (ring[0]),
      .query       (query_ff),
      .rows_in_use (rows_in_use_ff),
      .busy        (scan_busy),
      .best_idx    (best_idx),
      .best_tile   (best_tile)
   );

   assign div_m = (best_tile.tile_m == '0) ? TILE_W'(1) : best_tile.tile_m;
   assign div_n = (best_tile.tile_n == '0) ? TILE_W'(1) : best_tile.tile_n;

   nsc_div u_div_m (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (query_ff.dim_m),
      .divisor  (div_m),
      .busy     (busy_m),
      .quotient (quot_m)
   );

   nsc_div u_div_n (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (query_ff.dim_n),
      .divisor  (div_n),
      .busy     (busy_n),
      .quotient (quot_n)
   );

   always_comb begin
      state_in     = state_ff;
      shift_cnt_in = shift_cnt_ff;
      shift_en     = 1'b0;
      feed         = 1'b0;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.mode == MODE_QUERY)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            feed     = 1'b1;
            shift_en = 1'b1;
            if (shift_cnt_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               shift_cnt_in = '0;
               state_in     = ST_DRAIN;
            end else begin
               shift_cnt_in = shift_cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!scan_busy) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!(busy_m || busy_n) && (!rsp_valid_ff || rsp_ready)) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shift_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         shift_cnt_ff <= shift_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff <= CNT_W'(1);
      end else if (csr_valid && csr_ready) begin
         rows_in_use_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_data.mode == MODE_QUERY)) begin
         query_ff.dim_m <= req_data.dim_m;
         query_ff.dim_n <= req_data.dim_n;
         query_ff.dim_k <= req_data.dim_k;
         query_ff.dim_b <= req_data.dim_b;
      end
   end

   assign lhs_min = (quot_m < DIM_W'(best_tile.lhs_blocks)) ? quot_m
                                                             : DIM_W'(best_tile.lhs_blocks);
   assign rhs_min = (best_tile.rhs_blocks == '0) ? quot_n
                  : ((quot_n < DIM_W'(best_tile.rhs_blocks)) ? quot_n
                                                             : DIM_W'(best_tile.rhs_blocks));

   always_comb begin
      rsp_data_in.best_row         = ROW_IDX_W'(best_idx);
      rsp_data_in.out_tile_m       = best_tile.tile_m;
      rsp_data_in.out_tile_n       = best_tile.tile_n;
      rsp_data_in.out_tile_k       = best_tile.tile_k;
      rsp_data_in.out_lhs_blocks   = (lhs_min == '0) ? BLK_W'(1) : BLK_W'(lhs_min);
      rsp_data_in.out_rhs_blocks   = (rhs_min == '0) ? DIM_W'(1) : rhs_min;
      rsp_data_in.out_layout_flags = best_tile.layout_flags;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_ring_home : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN) |-> (shift_cnt_ff == '0))
      else $error("ring not at home position outside a scan");

   a_scan_end : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && shift_cnt_ff == IDX_W'(TABLE_DEPTH - 1)) |=>
      (state_ff == ST_DRAIN))
      else $error("scan did not end after a full rotation");

   a_div_lockstep : assert property (@(posedge clock) disable iff (reset)
      busy_m == busy_n)
      else $error("dividers out of step");

   a_div_after_drain : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> !scan_busy)
      else $error("division started with distance pipeline busy");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DIV))
      else $error("response raised outside the divide state");

endmodule
